// ===== sv/ffba_pkg.sv =====
// Package with shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int ADDR_W = 20;
   localparam int LEN_W  = 21;

   typedef enum logic [1:0] {
      KIND_INIT    = 2'd0,
      KIND_ALLOC   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_FULL     = 2'd2,
      ST_BAD_ADDR = 2'd3
   } status_type;

   localparam logic [7:0] REG_HEAP_PAGES = 8'd0;

endpackage

// ===== sv/ffba_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [20:0] request_size;
   logic [19:0] block_address;
   modport source (output valid, output kind, output request_size, output block_address,
                   input ready);
   modport sink   (input valid, input kind, input request_size, input block_address,
                   output ready);
endinterface

interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [19:0] data_address;
   modport source (output valid, output status, output data_address, input ready);
   modport sink   (input valid, input status, input data_address, output ready);
endinterface

// ===== sv/ffba_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: sequencer, block table memory and CSR.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid/ready      | kind, request_size, block_address
//   rsp     | out       | valid/ready      | status, data_address
//   csr     | in        | APB write/read   | heap_pages at byte address 0
//
// Allocate walks the link chain block by block; a split adds a free-slot search,
// writes the current and new blocks and, if a next block exists, its back link.
// Release scans the slots until it finds the hit block, reads its predecessor
// and may merge into it, which can also rewrite the next block's back link. The
// table has a single read port and is not cleared at reset; only the slot-in-use
// bits are. req.ready is high while the sequencer is idle; a finished command
// waits in the done state while the previous response has not been taken.
module first_fit_block_allocator_top #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 32,
   parameter int PAGE_BYTES   = 4096,
   parameter int MAX_PAGES    = 256
) (
   input  logic        clock,
   input  logic        reset,
   ffba_req_if.sink    req,
   ffba_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ffba_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int LW = IW + 1;   // link width, MAX_BLOCKS means no link
   localparam int EW = ADDR_W + LEN_W + 2 * LW + 1;
   localparam logic [LW-1:0] NO_LINK = LW'(MAX_BLOCKS);
   localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HEADER_BYTES);
   localparam logic [LEN_W:0] HDR_L = (LEN_W + 1)'(HEADER_BYTES);
   localparam logic [LEN_W:0] LEN_MAX = {1'b0, {LEN_W{1'b1}}};

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
      logic [LW-1:0]     prev;
      logic [LW-1:0]     next;
      logic              is_free;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_A_RD, S_A_CHK, S_F_SCAN, S_A_WCUR, S_A_WNEW, S_A_RDN, S_A_WN,
      S_R_RD, S_R_CHK, S_R_RDP, S_R_CHKP, S_R_RDN, S_R_WN, S_DONE
   } state_type;

   state_type            state_ff;
   logic [8:0]           pages_ff;
   logic [IW-1:0]        cur_ff;
   logic [IW:0]          cnt_ff;
   logic [IW-1:0]        fresh_ff;
   logic [LW-1:0]        pidx_ff;
   entry_type            ent_ff;
   entry_type            pent_ff;
   logic [LEN_W-1:0]     size_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [MAX_BLOCKS-1:0] used_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           status_ff;
   logic [ADDR_W-1:0]    data_ff;
   logic [1:0]           rsp_status_ff;
   logic [ADDR_W-1:0]    rsp_data_ff;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   entry_type            wr_data, rd_data;
   logic [EW-1:0]        rd_raw;

   ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   // CSR port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_HEAP_PAGES[1:0]) ? {23'd0, pages_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= 9'd2;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == REG_HEAP_PAGES[1:0]) begin
         pages_ff <= csr_pwdata[8:0];
      end
   end

   // Initial length of the arena.
   logic [8:0]   pages_c;
   logic [31:0]  arena;
   logic [LEN_W-1:0] init_len;
   always_comb begin
      pages_c = pages_ff;
      if (pages_c == 9'd0) begin
         pages_c = 9'd1;
      end
      if (32'(pages_c) > 32'(MAX_PAGES)) begin
         pages_c = 9'(MAX_PAGES);
      end
      arena = 32'(pages_c) * 32'(PAGE_BYTES);
      init_len = (arena > 32'(HEADER_BYTES)) ? LEN_W'(arena - 32'(HEADER_BYTES)) : '0;
   end

   logic link_ok_next, link_ok_prev;
   logic [LEN_W:0] rem, merge_sum;
   assign link_ok_next = (ent_ff.next < NO_LINK) && used_ff[ent_ff.next[IW-1:0]];
   assign link_ok_prev = (ent_ff.prev < NO_LINK) && used_ff[ent_ff.prev[IW-1:0]];
   assign rem = {1'b0, ent_ff.length} - {1'b0, size_ff};
   assign merge_sum = {1'b0, rd_data.length} + {1'b0, ent_ff.length} + HDR_L;

   logic req_fire;
   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // Memory access selection.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = ent_ff;
      rd_addr = cur_ff;
      case (state_ff)
         S_IDLE: begin
            wr_en = req_fire && (req.kind == KIND_INIT);
            wr_addr = '0;
            wr_data = '{start: '0, length: init_len, prev: NO_LINK, next: NO_LINK,
                        is_free: 1'b1};
         end
         S_A_WCUR: begin
            wr_en = 1'b1;
            wr_data = ent_ff;
            wr_data.is_free = 1'b0;
            wr_data.length = size_ff;
            if (rem > HDR_L) begin
               wr_data.next = LW'(fresh_ff);
            end
         end
         S_A_WNEW: begin
            wr_en = 1'b1;
            wr_addr = fresh_ff;
            wr_data = '{start: ent_ff.start + HDR_A + size_ff[ADDR_W-1:0]
                                + ADDR_W'(size_ff[LEN_W-1:ADDR_W] << ADDR_W),
                        length: LEN_W'(rem - HDR_L), prev: LW'(cur_ff),
                        next: ent_ff.next, is_free: 1'b1};
            rd_addr = ent_ff.next[IW-1:0];
         end
         S_A_WN: begin
            wr_en = 1'b1;
            wr_addr = ent_ff.next[IW-1:0];
            wr_data = rd_data;
            wr_data.prev = LW'(fresh_ff);
         end
         S_R_CHKP: begin
            // Free the hit block; a merge instead rewrites the predecessor's length and next.
            wr_en = !(link_ok_prev && rd_data.is_free);
            wr_data = ent_ff;
            wr_data.is_free = 1'b1;
            if (link_ok_prev && rd_data.is_free) begin
               wr_en = 1'b1;
               wr_addr = pidx_ff[IW-1:0];
               wr_data = rd_data;
               wr_data.length = (merge_sum > LEN_MAX) ? LEN_MAX[LEN_W-1:0]
                                                      : merge_sum[LEN_W-1:0];
               wr_data.next = ent_ff.next;
            end
            rd_addr = ent_ff.next[IW-1:0];
         end
         S_R_WN: begin
            wr_en = 1'b1;
            wr_addr = ent_ff.next[IW-1:0];
            wr_data = pent_ff;
            wr_data.prev = pidx_ff;
         end
         S_R_CHK, S_R_RD: rd_addr = cnt_ff[IW-1:0];
         S_R_RDP: rd_addr = ent_ff.prev[IW-1:0];
         S_A_RDN: rd_addr = ent_ff.next[IW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  size_ff <= req.request_size;
                  addr_ff <= req.block_address;
                  cur_ff <= '0;
                  cnt_ff <= '0;
                  status_ff <= ST_OK;
                  data_ff <= '0;
                  case (kind_type'(req.kind))
                     KIND_INIT: begin
                        used_ff <= MAX_BLOCKS'(1);
                        state_ff <= S_DONE;
                     end
                     KIND_ALLOC: state_ff <= used_ff[0] ? S_A_RD : S_DONE;
                     KIND_RELEASE: state_ff <= S_R_RD;
                     default: state_ff <= S_DONE;
                  endcase
                  if (req.kind == KIND_ALLOC && !used_ff[0]) begin
                     status_ff <= ST_NO_FIT;
                  end
               end
            end
            S_A_RD: state_ff <= S_A_CHK;
            S_A_CHK: begin
               ent_ff <= rd_data;
               cnt_ff <= cnt_ff + 1'b1;
               if (rd_data.is_free && rd_data.length >= size_ff) begin
                  fresh_ff <= '0;
                  state_ff <= S_F_SCAN;
               end else if (32'(cnt_ff) + 1 < MAX_BLOCKS && rd_data.next < NO_LINK &&
                            used_ff[rd_data.next[IW-1:0]]) begin
                  cur_ff <= rd_data.next[IW-1:0];
                  state_ff <= S_A_RD;
               end else begin
                  status_ff <= ST_NO_FIT;
                  state_ff <= S_DONE;
               end
            end
            S_F_SCAN: begin
               if (!(rem > HDR_L)) begin
                  state_ff <= S_A_WCUR;
               end else if (!used_ff[fresh_ff]) begin
                  state_ff <= S_A_WCUR;
               end else if (32'(fresh_ff) == MAX_BLOCKS - 1) begin
                  status_ff <= ST_FULL;
                  state_ff <= S_DONE;
               end else begin
                  fresh_ff <= fresh_ff + 1'b1;
               end
            end
            S_A_WCUR: begin
               data_ff <= ent_ff.start + HDR_A;
               if (rem > HDR_L) begin
                  used_ff[fresh_ff] <= 1'b1;
                  state_ff <= S_A_WNEW;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_A_WNEW: state_ff <= link_ok_next ? S_A_RDN : S_DONE;
            S_A_RDN: state_ff <= S_A_WN;
            S_A_WN: state_ff <= S_DONE;
            S_R_RD: state_ff <= S_R_CHK;
            S_R_CHK: begin
               if (used_ff[cnt_ff[IW-1:0]] && !rd_data.is_free &&
                   (rd_data.start + HDR_A) == addr_ff) begin
                  ent_ff <= rd_data;
                  cur_ff <= cnt_ff[IW-1:0];
                  state_ff <= S_R_RDP;
               end else if (32'(cnt_ff) == MAX_BLOCKS - 1) begin
                  status_ff <= ST_BAD_ADDR;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_R_RD;
               end
            end
            S_R_RDP: begin
               pidx_ff <= ent_ff.prev;
               state_ff <= S_R_CHKP;
            end
            S_R_CHKP: begin
               if (link_ok_prev && rd_data.is_free) begin
                  used_ff[cur_ff] <= 1'b0;
                  state_ff <= link_ok_next ? S_R_RDN : S_DONE;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_R_RDN: begin
               pent_ff <= rd_data;
               state_ff <= S_R_WN;
            end
            S_R_WN: state_ff <= S_DONE;
            S_DONE: begin
               // The result moves to the output register once it is free.
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_data_ff <= data_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.data_address = rsp_data_ff;

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == S_IDLE))
      else $error("ready while busy");
   a_slot0_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_RD) |-> used_ff[0])
      else $error("walk without first block");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid_ff)
      else $error("response lost");
   a_addr_zero_on_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_data_ff == '0)
      else $error("address on failed request");
`endif
endmodule
